### rtl/wsht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsht_pkg
// Shared types and codes for the window stack hit test block.
// ----------------------------------------------------------------------------
package wsht_pkg;

  // width of a window id on the result channel
  localparam int unsigned ID_W = 5;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CLICK = 1'b1;

  // control sent from the sequencer to every cell of the stack
  typedef struct packed {
    logic probe;  // capture hit flag for the click point on the input
    logic load;   // push a new window on top, every cell shifts down
    logic move;   // a click hit: cells down to the first hit shift down
  } wsht_ctrl_t;

endpackage

### rtl/wsht_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsht_in_if / wsht_out_if
// Valid/ready channels for the window stack hit test block.
// ----------------------------------------------------------------------------
interface wsht_in_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COORD_BITS-1:0] x_low;
  logic [COORD_BITS-1:0] y_low;
  logic [COORD_BITS-1:0] x_high;
  logic [COORD_BITS-1:0] y_high;

  modport source (output valid, operation, x_low, y_low, x_high, y_high, input ready);
  modport sink   (input valid, operation, x_low, y_low, x_high, y_high, output ready);
endinterface

interface wsht_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] window_id;
  logic       ignored;
  logic       store_full;

  modport source (output valid, window_id, ignored, store_full, input ready);
  modport sink   (input valid, window_id, ignored, store_full, output ready);
endinterface

### rtl/wsht_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsht_cell
// One stack position: holds a window rectangle and its id, tests a click
// point against it and shifts in its upper neighbor's window.
// ----------------------------------------------------------------------------
module wsht_cell
  import wsht_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wsht_ctrl_t            ctrl_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic                  hit_above_i,
  output logic                  hit_above_o,
  output logic                  first_o,
  input  logic [COORD_BITS-1:0] prev_xl_i,
  input  logic [COORD_BITS-1:0] prev_yl_i,
  input  logic [COORD_BITS-1:0] prev_xh_i,
  input  logic [COORD_BITS-1:0] prev_yh_i,
  input  logic [ID_W-1:0]       prev_id_i,
  output logic [COORD_BITS-1:0] xl_o,
  output logic [COORD_BITS-1:0] yl_o,
  output logic [COORD_BITS-1:0] xh_o,
  output logic [COORD_BITS-1:0] yh_o,
  output logic [ID_W-1:0]       id_o
);

  logic [COORD_BITS-1:0] xl_q, yl_q, xh_q, yh_q;
  logic [ID_W-1:0]       id_q;
  logic                  hit_q, hit_d;
  logic                  occupied;
  logic                  shift;

  assign occupied = (CNT_W'(IDX) < count_i);

  // closed rectangle, edges inside
  assign hit_d = occupied && (px_i >= xl_q) && (px_i <= xh_q)
                          && (py_i >= yl_q) && (py_i <= yh_q);

  assign hit_above_o = hit_above_i | hit_q;
  assign first_o     = hit_q & ~hit_above_i;
  assign shift       = ctrl_i.load | (ctrl_i.move & ~hit_above_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.probe) begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      xl_q <= prev_xl_i;
      yl_q <= prev_yl_i;
      xh_q <= prev_xh_i;
      yh_q <= prev_yh_i;
      id_q <= prev_id_i;
    end
  end

  assign xl_o = xl_q;
  assign yl_o = yl_q;
  assign xh_o = xh_q;
  assign yh_o = yh_q;
  assign id_o = id_q;

endmodule

### rtl/window_stack_hit_test_move_to_front_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_stack_hit_test_move_to_front_top
// Window z-order stack with click hit test and move to front.
// ----------------------------------------------------------------------------
// The stack is a row of MAX_WINDOWS cells, position 0 on top, each holding one
// window rectangle and its id. An item passes the accept cycle, in which, for
// a click, every cell compares the click point against its rectangle and
// keeps a hit flag, then the execute state, in which the first hit is found
// along the cell row and the cells shift down one place (all of them for a
// load that fits, those down to the hit for a click that hits) while the
// result is registered. The input is ready again as soon as the result is
// registered, so a new item can be taken while that result waits; a result
// that is not taken holds the next item in its execute state. There is no
// clearing pass after reset: only positions below the window count are tested.
// ----------------------------------------------------------------------------
module window_stack_hit_test_move_to_front_top
  import wsht_pkg::*;
#(
  parameter int unsigned MAX_WINDOWS = 16,
  parameter int unsigned COORD_BITS  = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  wsht_in_if.sink           in_i,
  wsht_out_if.source        out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_WINDOWS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                  state_q, state_d;
  logic                  op_q;
  logic [COORD_BITS-1:0] xl_q, yl_q, xh_q, yh_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  logic [ID_W-1:0]       out_id_q, out_id_d;
  logic                  out_ign_q, out_ign_d;
  logic                  out_full_q, out_full_d;

  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic                  is_full;
  logic                  any_hit;
  logic [ID_W-1:0]       new_id;
  wsht_ctrl_t            ctrl;

  logic [COORD_BITS-1:0] cell_xl [MAX_WINDOWS];
  logic [COORD_BITS-1:0] cell_yl [MAX_WINDOWS];
  logic [COORD_BITS-1:0] cell_xh [MAX_WINDOWS];
  logic [COORD_BITS-1:0] cell_yh [MAX_WINDOWS];
  logic [ID_W-1:0]       cell_id [MAX_WINDOWS];
  logic [COORD_BITS-1:0] prev_xl [MAX_WINDOWS];
  logic [COORD_BITS-1:0] prev_yl [MAX_WINDOWS];
  logic [COORD_BITS-1:0] prev_xh [MAX_WINDOWS];
  logic [COORD_BITS-1:0] prev_yh [MAX_WINDOWS];
  logic [ID_W-1:0]       prev_id [MAX_WINDOWS];
  logic                  hit_above [MAX_WINDOWS+1];
  logic [MAX_WINDOWS-1:0] first;

  logic [COORD_BITS-1:0] sel_xl, sel_yl, sel_xh, sel_yh;
  logic [ID_W-1:0]       sel_id;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign finish     = (state_q == ST_EXEC) && out_free;
  assign is_full    = (count_q == CNT_W'(MAX_WINDOWS));
  assign any_hit    = hit_above[MAX_WINDOWS];
  assign new_id     = ID_W'(count_q + 1'b1);

  assign ctrl.probe = accept && (in_i.operation == OP_CLICK);
  assign ctrl.load  = finish && (op_q == OP_LOAD) && !is_full;
  assign ctrl.move  = finish && (op_q == OP_CLICK) && any_hit;

  // window found by the click, picked out of the row by its one-hot flag
  always_comb begin
    sel_xl = '0;
    sel_yl = '0;
    sel_xh = '0;
    sel_yh = '0;
    sel_id = '0;
    for (int i = 0; i < MAX_WINDOWS; i++) begin
      if (first[i]) begin
        sel_xl = sel_xl | cell_xl[i];
        sel_yl = sel_yl | cell_yl[i];
        sel_xh = sel_xh | cell_xh[i];
        sel_yh = sel_yh | cell_yh[i];
        sel_id = sel_id | cell_id[i];
      end
    end
  end

  assign hit_above[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
    if (i == 0) begin : g_top
      assign prev_xl[i] = (op_q == OP_LOAD) ? xl_q   : sel_xl;
      assign prev_yl[i] = (op_q == OP_LOAD) ? yl_q   : sel_yl;
      assign prev_xh[i] = (op_q == OP_LOAD) ? xh_q   : sel_xh;
      assign prev_yh[i] = (op_q == OP_LOAD) ? yh_q   : sel_yh;
      assign prev_id[i] = (op_q == OP_LOAD) ? new_id : sel_id;
    end else begin : g_below
      assign prev_xl[i] = cell_xl[i-1];
      assign prev_yl[i] = cell_yl[i-1];
      assign prev_xh[i] = cell_xh[i-1];
      assign prev_yh[i] = cell_yh[i-1];
      assign prev_id[i] = cell_id[i-1];
    end

    wsht_cell #(
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .px_i        (in_i.x_low),
      .py_i        (in_i.y_low),
      .hit_above_i (hit_above[i]),
      .hit_above_o (hit_above[i+1]),
      .first_o     (first[i]),
      .prev_xl_i   (prev_xl[i]),
      .prev_yl_i   (prev_yl[i]),
      .prev_xh_i   (prev_xh[i]),
      .prev_yh_i   (prev_yh[i]),
      .prev_id_i   (prev_id[i]),
      .xl_o        (cell_xl[i]),
      .yl_o        (cell_yl[i]),
      .xh_o        (cell_xh[i]),
      .yh_o        (cell_yh[i]),
      .id_o        (cell_id[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_id_d    = out_id_q;
    out_ign_d   = out_ign_q;
    out_full_d  = out_full_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_id_d    = '0;
          out_ign_d   = 1'b0;
          out_full_d  = 1'b0;
          if (op_q == OP_LOAD) begin
            if (is_full) begin
              out_full_d = 1'b1;
            end else begin
              out_id_d = new_id;
              count_d  = count_q + 1'b1;
            end
          end else if (any_hit) begin
            out_id_d = sel_id;
          end else begin
            out_ign_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_i.operation;
      xl_q <= in_i.x_low;
      yl_q <= in_i.y_low;
      xh_q <= in_i.x_high;
      yh_q <= in_i.y_high;
    end
    out_id_q   <= out_id_d;
    out_ign_q  <= out_ign_d;
    out_full_q <= out_full_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.window_id  = out_id_q;
  assign out_o.ignored    = out_ign_q;
  assign out_o.store_full = out_full_q;

endmodule

### rtl/wsht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsht_checker
// Port-level checks for the window stack hit test block.
// ----------------------------------------------------------------------------
module wsht_checker
  import wsht_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [ID_W-1:0] window_id_i,
  input logic            ignored_i,
  input logic            store_full_i
);

  // one item at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transaction");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(ignored_i && store_full_i))
    else $error("ignored and store_full both set");

  a_no_id_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (ignored_i || store_full_i) |-> window_id_i == '0)
    else $error("window id given with a failed item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(window_id_i)
      && $stable(ignored_i) && $stable(store_full_i))
    else $error("stalled result changed");

endmodule

bind window_stack_hit_test_move_to_front_top wsht_checker u_wsht_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .window_id_i  (out_o.window_id),
  .ignored_i    (out_o.ignored),
  .store_full_i (out_o.store_full)
);

### bench/window_stack_hit_test_move_to_front_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_stack_hit_test_move_to_front_top_tb
// Self-checking bench for the window z-order stack with hit test.
// ----------------------------------------------------------------------------
// A directed table loads the stack to capacity with edge, point and inverted
// rectangles, clicks on corners and misses, and overflows the store. Random
// clicks aimed inside, on and just past window edges then reshuffle the
// z-order. Each transaction is checked against the table or a local model of
// the stack while both channels idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module window_stack_hit_test_move_to_front_top_tb;
  import wsht_pkg::*;

  localparam int unsigned MAX_WINDOWS = 16;
  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned RAND_ITEMS  = 1500;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic   operation;
    coord_t x_low;
    coord_t y_low;
    coord_t x_high;
    coord_t y_high;
  } window_cmd_t;

  typedef struct packed {
    logic [ID_W-1:0] window_id;
    logic            ignored;
    logic            store_full;
  } window_res_t;

  typedef struct packed {
    window_cmd_t cmd;
    logic        typed;  // res below is the expected result
    window_res_t res;
  } dir_row_t;

  localparam window_res_t MISS = '{5'd0, 1'b1, 1'b0};
  localparam window_res_t FULL = '{5'd0, 1'b0, 1'b1};
  localparam window_res_t NONE = '0;

  localparam int unsigned DIR_COUNT = 26;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{'{OP_CLICK, 12'd0,    12'd0,    12'd0,    12'd0},    1'b1, MISS},
    '{'{OP_LOAD,  12'd0,    12'd0,    12'd4095, 12'd4094}, 1'b1, '{5'd1, 1'b0, 1'b0}},
    '{'{OP_CLICK, 12'd0,    12'd0,    12'd0,    12'd0},    1'b1, '{5'd1, 1'b0, 1'b0}},
    '{'{OP_CLICK, 12'd4095, 12'd4094, 12'd0,    12'd0},    1'b1, '{5'd1, 1'b0, 1'b0}},
    '{'{OP_CLICK, 12'd4095, 12'd4095, 12'd0,    12'd0},    1'b1, MISS},
    '{'{OP_LOAD,  12'd100,  12'd200,  12'd100,  12'd200},  1'b1, '{5'd2, 1'b0, 1'b0}},
    '{'{OP_CLICK, 12'd100,  12'd200,  12'd0,    12'd0},    1'b0, NONE},
    '{'{OP_LOAD,  12'd500,  12'd500,  12'd400,  12'd600},  1'b1, '{5'd3, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd10,   12'd30,   12'd20,   12'd5},    1'b1, '{5'd4, 1'b0, 1'b0}},
    '{'{OP_CLICK, 12'd450,  12'd550,  12'd0,    12'd0},    1'b0, NONE},
    '{'{OP_LOAD,  12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1, '{5'd5, 1'b0, 1'b0}},
    '{'{OP_CLICK, 12'd4095, 12'd4095, 12'd0,    12'd0},    1'b0, NONE},
    '{'{OP_LOAD,  12'd0,    12'd0,    12'd0,    12'd0},    1'b1, '{5'd6, 1'b0, 1'b0}},
    '{'{OP_CLICK, 12'd0,    12'd0,    12'd4095, 12'd4095}, 1'b0, NONE},
    '{'{OP_LOAD,  12'd1000, 12'd1000, 12'd2999, 12'd2999}, 1'b1, '{5'd7, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd1500, 12'd500,  12'd2500, 12'd3500}, 1'b1, '{5'd8, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd500,  12'd1500, 12'd3500, 12'd2500}, 1'b1, '{5'd9, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd2000, 12'd2000, 12'd2000, 12'd2000}, 1'b1, '{5'd10, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd0,    12'd2048, 12'd2047, 12'd4095}, 1'b1, '{5'd11, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd2048, 12'd0,    12'd4095, 12'd2047}, 1'b1, '{5'd12, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd1900, 12'd1900, 12'd2100, 12'd2100}, 1'b1, '{5'd13, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd3000, 12'd3000, 12'd3100, 12'd3100}, 1'b1, '{5'd14, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd1,    12'd1,    12'd4094, 12'd4094}, 1'b1, '{5'd15, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd2047, 12'd2047, 12'd2049, 12'd2049}, 1'b1, '{5'd16, 1'b0, 1'b0}},
    '{'{OP_LOAD,  12'd1,    12'd2,    12'd3,    12'd4},    1'b1, FULL},
    '{'{OP_CLICK, 12'd2048, 12'd2048, 12'd0,    12'd0},    1'b0, NONE}
  };

  logic clk_i;
  logic rst_ni;

  wsht_in_if #(.COORD_BITS(COORD_BITS)) in_if ();
  wsht_out_if out_if ();

  window_stack_hit_test_move_to_front_top #(
    .MAX_WINDOWS(MAX_WINDOWS),
    .COORD_BITS (COORD_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // model of the stack: rectangle of id k at entry k-1, z_order[0] on top
  coord_t          win_xl [MAX_WINDOWS];
  coord_t          win_yl [MAX_WINDOWS];
  coord_t          win_xh [MAX_WINDOWS];
  coord_t          win_yh [MAX_WINDOWS];
  logic [ID_W-1:0] z_order [MAX_WINDOWS];
  int unsigned     win_count = 0;

  window_res_t res_pending [$];
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  function automatic window_res_t stack_apply(window_cmd_t c);
    window_res_t r;
    int          hit_pos;
    logic [ID_W-1:0] w;
    r = '0;
    hit_pos = -1;
    if (c.operation == OP_LOAD) begin
      if (win_count >= MAX_WINDOWS) begin
        r.store_full = 1'b1;
      end else begin
        win_xl[win_count] = c.x_low;
        win_yl[win_count] = c.y_low;
        win_xh[win_count] = c.x_high;
        win_yh[win_count] = c.y_high;
        for (int k = win_count; k > 0; k--) z_order[k] = z_order[k-1];
        win_count++;
        z_order[0] = ID_W'(win_count);
        r.window_id = ID_W'(win_count);
      end
    end else begin
      for (int p = 0; p < win_count; p++) begin
        w = z_order[p];
        if (c.x_low >= win_xl[w-1] && c.x_low <= win_xh[w-1] &&
            c.y_low >= win_yl[w-1] && c.y_low <= win_yh[w-1]) begin
          hit_pos = p;
          break;
        end
      end
      if (hit_pos >= 0) begin
        w = z_order[hit_pos];
        for (int k = hit_pos; k > 0; k--) z_order[k] = z_order[k-1];
        z_order[0] = w;
        r.window_id = w;
      end else begin
        r.ignored = 1'b1;
      end
    end
    return r;
  endfunction

  // a coordinate on, just past or inside the span lo..hi
  function automatic coord_t near_edge(coord_t lo, coord_t hi);
    coord_t v;
    case ($urandom_range(4))
      0: v = lo;
      1: v = hi;
      2: v = lo - 1'b1;
      3: v = hi + 1'b1;
      default: v = coord_t'($urandom_range(hi, lo));
    endcase
    return v;
  endfunction

  task automatic send_cmd(input window_cmd_t cmd, input logic typed, input window_res_t res);
    window_res_t predicted;
    @(negedge clk_i);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= cmd.operation;
    in_if.x_low     <= cmd.x_low;
    in_if.y_low     <= cmd.y_low;
    in_if.x_high    <= cmd.x_high;
    in_if.y_high    <= cmd.y_high;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = stack_apply(cmd);
    res_pending.push_back(typed ? res : predicted);
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    window_res_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (res_pending.size() == 0) begin
        $error("unexpected transaction: window_id %0d ignored %0b store_full %0b",
               out_if.window_id, out_if.ignored, out_if.store_full);
        fail_count++;
      end else begin
        exp_res = res_pending.pop_front();
        if (out_if.window_id !== exp_res.window_id) begin
          $error("window_id: expected %0d, got %0d", exp_res.window_id, out_if.window_id);
          fail_count++;
        end
        if (out_if.ignored !== exp_res.ignored) begin
          $error("ignored: expected %0b, got %0b", exp_res.ignored, out_if.ignored);
          fail_count++;
        end
        if (out_if.store_full !== exp_res.store_full) begin
          $error("store_full: expected %0b, got %0b", exp_res.store_full, out_if.store_full);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    window_cmd_t cmd;
    int unsigned pick;
    int unsigned mode;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_LOAD;
    in_if.x_low      = '0;
    in_if.y_low      = '0;
    in_if.x_high     = '0;
    in_if.y_high     = '0;
    out_if.ready     = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIR_COUNT; i++) begin
      send_cmd(DIR_ROWS[i].cmd, DIR_ROWS[i].typed, DIR_ROWS[i].res);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        cmd.x_low  = coord_t'($urandom);
        cmd.y_low  = coord_t'($urandom);
        cmd.x_high = coord_t'($urandom);
        cmd.y_high = coord_t'($urandom);
        if ($urandom_range(99) < 8) begin
          cmd.operation = OP_LOAD;
        end else begin
          // aim most clicks at a stored window so hits reshuffle the order
          cmd.operation = OP_CLICK;
          pick = $urandom_range(win_count - 1);
          mode = $urandom_range(99);
          if (mode < 55) begin
            cmd.x_low = coord_t'($urandom_range(win_xh[pick], win_xl[pick]));
            cmd.y_low = coord_t'($urandom_range(win_yh[pick], win_yl[pick]));
          end else if (mode < 85) begin
            cmd.x_low = near_edge(win_xl[pick], win_xh[pick]);
            cmd.y_low = near_edge(win_yl[pick], win_yh[pick]);
          end
        end
        send_cmd(cmd, 1'b0, NONE);
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (res_pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
